// ----- design/womon_pkg.sv -----
// Shared types and constants of the wheel odometry and obstacle monitor.
`default_nettype none

package womon_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_OPC_ULTRA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPC_HALL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPC_HSPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;

  localparam int OPC_W     = 8;
  localparam int CIRC_W    = 16;
  localparam int RATE_W    = 20;
  localparam int TIMEOUT_W = 24;
  localparam int DIST_W    = 32;
  localparam int SPEED_W   = 16;

  localparam logic [OPC_W-1:0]     RST_OPC_ULTRA  = 8'd1;
  localparam logic [OPC_W-1:0]     RST_OPC_HALL   = 8'd2;
  localparam logic [OPC_W-1:0]     RST_OPC_HSPEED = 8'd3;
  localparam logic [CIRC_W-1:0]    RST_CIRC       = 16'd240;
  localparam logic [RATE_W-1:0]    RST_RATE       = 20'd1000;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 24'd500;

  // item kinds and ultrasonic codes
  localparam logic       ACT_TICK     = 1'b0;
  localparam logic       ACT_MSG      = 1'b1;
  localparam logic [7:0] ULTRA_CLEAR  = 8'd0;
  localparam logic [7:0] ULTRA_STOP   = 8'd1;
  localparam logic       STOP_PAYLOAD = 1'b1;

  // divider: dividend is circumference times tick rate
  localparam int NUM_W     = CIRC_W + RATE_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SPEED,
    ST_PUB
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic speed_wr;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/wheel_odometry_obstacle_monitor_core.sv -----
// Top level of the wheel odometry and obstacle monitor.
//
//   channel  ports                                   transfer
//   in       in_valid/in_ready, in_action..          one tick or sensor message
//   out      out_valid/out_ready, out_obstacle_flag  one status beat per input beat
//   cfg      cfg_we, cfg_index, cfg_data             register write, no wait
//
// Ticks, ultrasonic, speed and unknown messages: execute, then publish, with no division.
// Hall pulse with a measured interval: execute, the 36-step serial divider, speed write, publish.
// Reset is synchronous, active low; config registers return to their defaults.
// A new beat is taken while the previous result waits in the output register;
// a stalled output only holds the block once the next result is ready.
`default_nettype none

module wheel_odometry_obstacle_monitor_core
  import womon_pkg::*;
#(
  parameter int PULSE_COUNT_BITS = 24,
  parameter int TICK_COUNT_BITS  = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_action,
  input  wire  [OPC_W-1:0]      in_opcode,
  input  wire  [7:0]            in_data,
  input  wire                   in_clear_distance,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_obstacle_flag,
  output logic                  out_stop_message_valid,
  output logic                  out_stop_message_data,
  output logic [DIST_W-1:0]     out_distance_mm,
  output logic [SPEED_W-1:0]    out_speed_mm_per_s
);

  cmd_t cmd;
  sts_t sts;

  womon_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  womon_dp #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
    .TICK_COUNT_BITS  (TICK_COUNT_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_action              (in_action),
    .in_opcode              (in_opcode),
    .in_data                (in_data),
    .in_clear_distance      (in_clear_distance),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_obstacle_flag      (out_obstacle_flag),
    .out_stop_message_valid (out_stop_message_valid),
    .out_stop_message_data  (out_stop_message_data),
    .out_distance_mm        (out_distance_mm),
    .out_speed_mm_per_s     (out_speed_mm_per_s)
  );

endmodule

`default_nettype wire

// ----- design/womon_ctrl.sv -----
// Sequencing controller of the odometry and obstacle monitor.
`default_nettype none

module womon_ctrl
  import womon_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts_i.need_div ? ST_DIV : ST_PUB;
      end
      ST_DIV: begin
        if (sts_i.div_last) state_nxt = ST_SPEED;
      end
      ST_SPEED: begin
        state_nxt = ST_PUB;
      end
      ST_PUB: begin
        if (sts_i.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd_o          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_SPEED: begin
        cmd_o.speed_wr = 1'b1;
      end
      ST_PUB: begin
        cmd_o.publish = sts_i.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> (state_r == ST_EXEC))
    else $error("accepted beat not followed by execute");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.publish |-> sts_i.out_free)
    else $error("result written while output register occupied");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts_i.div_last) |=> (state_r == ST_SPEED))
    else $error("divider did not hand over to speed write");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (!in_ready && !cmd_o.publish))
    else $error("input or output active during division");
`endif

endmodule

`default_nettype wire

// ----- design/womon_dp.sv -----
// Datapath: config registers, odometry state, serial divider, output register.
`default_nettype none

module womon_dp
  import womon_pkg::*;
#(
  parameter int PULSE_COUNT_BITS = 24,
  parameter int TICK_COUNT_BITS  = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire  [CFG_IDX_W-1:0]      cfg_index,
  input  wire  [CFG_DATA_W-1:0]     cfg_data,
  input  wire                       in_action,
  input  wire  [OPC_W-1:0]          in_opcode,
  input  wire  [7:0]                in_data,
  input  wire                       in_clear_distance,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic                      out_obstacle_flag,
  output logic                      out_stop_message_valid,
  output logic                      out_stop_message_data,
  output logic [DIST_W-1:0]         out_distance_mm,
  output logic [SPEED_W-1:0]        out_speed_mm_per_s
);

  localparam int PB = PULSE_COUNT_BITS;
  localparam int TB = TICK_COUNT_BITS;

  // configuration
  logic [OPC_W-1:0]     opc_ultra_r, opc_hall_r, opc_hspeed_r;
  logic [CIRC_W-1:0]    circ_r;
  logic [RATE_W-1:0]    rate_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opc_ultra_r  <= RST_OPC_ULTRA;
      opc_hall_r   <= RST_OPC_HALL;
      opc_hspeed_r <= RST_OPC_HSPEED;
      circ_r       <= RST_CIRC;
      rate_r       <= RST_RATE;
      timeout_r    <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPC_ULTRA:  opc_ultra_r  <= cfg_data[OPC_W-1:0];
        REG_OPC_HALL:   opc_hall_r   <= cfg_data[OPC_W-1:0];
        REG_OPC_HSPEED: opc_hspeed_r <= cfg_data[OPC_W-1:0];
        REG_CIRC:       circ_r       <= cfg_data[CIRC_W-1:0];
        REG_RATE:       rate_r       <= cfg_data[RATE_W-1:0];
        REG_TIMEOUT:    timeout_r    <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic             act_r;
  logic [OPC_W-1:0] opc_r;
  logic [7:0]       data_r;
  logic             clr_r;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      act_r  <= in_action;
      opc_r  <= in_opcode;
      data_r <= in_data;
      clr_r  <= in_clear_distance;
    end
  end

  // odometry state
  logic               obstacle_r, obstacle_nxt;
  logic [7:0]         last_byte_r, last_byte_nxt;
  logic               ultra_seen_r, ultra_seen_nxt;
  logic [PB-1:0]      pulse_r, pulse_nxt;
  logic [TB-1:0]      ticks_r, ticks_nxt;
  logic               hall_seen_r, hall_seen_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic               msg_valid_r, msg_valid_nxt;
  logic               msg_data_r, msg_data_nxt;

  // divider
  logic [NUM_W-1:0]     div_num_r;
  logic [TB-1:0]        div_rem_r;
  logic [TB-1:0]        div_den_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [NUM_W-1:0]     num_prod;
  logic [TB:0]          trial;
  logic [TB:0]          diff;
  logic                 trial_ge;
  logic [SPEED_W-1:0]   speed_sat;

  logic               is_ultra, is_hall, is_hspeed;
  logic [TB-1:0]      ticks_inc, ticks_eff;
  logic               timed_out;
  logic               need_div;
  logic [SPEED_W-1:0] hspeed;

  assign is_ultra  = (act_r == ACT_MSG) && (opc_r == opc_ultra_r);
  assign is_hall   = (act_r == ACT_MSG) && !is_ultra && (opc_r == opc_hall_r);
  assign is_hspeed = (act_r == ACT_MSG) && !is_ultra && !is_hall
                     && (opc_r == opc_hspeed_r);
  assign ticks_inc = (ticks_r != '1) ? ticks_r + 1'b1 : ticks_r;
  assign ticks_eff = (act_r == ACT_TICK) ? ticks_inc : ticks_r;
  assign timed_out = 64'(ticks_eff) > 64'(timeout_r);
  assign need_div  = is_hall && hall_seen_r && (ticks_r != '0);
  // data * 10 as two shifts
  assign hspeed    = (SPEED_W'(data_r) << 3) + (SPEED_W'(data_r) << 1);

  always_comb begin
    obstacle_nxt   = obstacle_r;
    last_byte_nxt  = last_byte_r;
    ultra_seen_nxt = ultra_seen_r;
    pulse_nxt      = pulse_r;
    ticks_nxt      = ticks_r;
    hall_seen_nxt  = hall_seen_r;
    speed_nxt      = speed_r;
    msg_valid_nxt  = msg_valid_r;
    msg_data_nxt   = msg_data_r;
    if (cmd_i.exec) begin
      msg_valid_nxt = 1'b0;
      msg_data_nxt  = 1'b0;
      if (timed_out) speed_nxt = '0;
      if (act_r == ACT_TICK) begin
        ticks_nxt = ticks_inc;
      end else if (is_ultra) begin
        if (!ultra_seen_r || (data_r != last_byte_r)) begin
          last_byte_nxt  = data_r;
          ultra_seen_nxt = 1'b1;
          if (data_r == ULTRA_STOP) begin
            obstacle_nxt  = 1'b1;
            msg_valid_nxt = 1'b1;
            msg_data_nxt  = STOP_PAYLOAD;
          end else if (data_r == ULTRA_CLEAR) begin
            obstacle_nxt  = 1'b0;
            msg_valid_nxt = 1'b1;
            msg_data_nxt  = 1'b0;
          end
        end
      end else if (is_hall) begin
        if (clr_r) begin
          pulse_nxt = '0;
        end else if (pulse_r != '1) begin
          pulse_nxt = pulse_r + 1'b1;
        end
        // with a division pending the speed is written once it finishes
        if (!need_div) speed_nxt = '0;
        hall_seen_nxt = 1'b1;
        ticks_nxt     = '0;
      end else if (is_hspeed) begin
        speed_nxt = hspeed;
      end
    end else if (cmd_i.speed_wr) begin
      speed_nxt = speed_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r   <= 1'b0;
      last_byte_r  <= '0;
      ultra_seen_r <= 1'b0;
      pulse_r      <= '0;
      ticks_r      <= '0;
      hall_seen_r  <= 1'b0;
      speed_r      <= '0;
      msg_valid_r  <= 1'b0;
      msg_data_r   <= 1'b0;
    end else begin
      obstacle_r   <= obstacle_nxt;
      last_byte_r  <= last_byte_nxt;
      ultra_seen_r <= ultra_seen_nxt;
      pulse_r      <= pulse_nxt;
      ticks_r      <= ticks_nxt;
      hall_seen_r  <= hall_seen_nxt;
      speed_r      <= speed_nxt;
      msg_valid_r  <= msg_valid_nxt;
      msg_data_r   <= msg_data_nxt;
    end
  end

  // restoring division, one quotient bit per cycle; quotient shifts into div_num_r
  assign num_prod  = circ_r * rate_r;
  assign trial     = {div_rem_r, div_num_r[NUM_W-1]};
  assign diff      = trial - {1'b0, div_den_r};
  assign trial_ge  = trial >= {1'b0, div_den_r};
  assign speed_sat = (div_num_r[NUM_W-1:SPEED_W] != '0) ? '1 : div_num_r[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      div_num_r <= num_prod;
      div_rem_r <= '0;
      div_den_r <= ticks_r;
      div_cnt_r <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_r <= trial_ge ? diff[TB-1:0] : trial[TB-1:0];
      div_num_r <= {div_num_r[NUM_W-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // distance, saturated to 32 bits
  logic [PB+CIRC_W-1:0] dist_prod;
  logic [63:0]          dist_wide;
  logic [DIST_W-1:0]    dist_sat;

  assign dist_prod = pulse_r * circ_r;
  assign dist_wide = 64'(dist_prod);
  assign dist_sat  = (dist_wide[63:DIST_W] != '0) ? '1 : dist_wide[DIST_W-1:0];

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.publish) begin
      out_obstacle_flag      <= obstacle_r;
      out_stop_message_valid <= msg_valid_r;
      out_stop_message_data  <= msg_data_r;
      out_distance_mm        <= dist_sat;
      out_speed_mm_per_s     <= speed_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign sts_o.need_div = need_div;
  assign sts_o.div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts_o.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire
